>>> rtl/bmpd_pkg.sv
// bmpd_pkg: item types, status codes and size limits for the bmp stream decoder
// no dependencies; imported by bmp_stream_rgb_decoder_unit
package bmpd_pkg;

	localparam int unsigned MAX_WIDTH  = 4096;
	localparam int unsigned MAX_HEIGHT = 4096;

	localparam logic [15:0] BMP_SIGNATURE  = 16'h4D42;
	localparam logic [31:0] MIN_PIX_OFFSET = 32'd54;
	localparam logic [31:0] MIN_INFO_SIZE  = 32'd40;
	localparam logic [15:0] BPP_24         = 16'd24;
	localparam logic [15:0] BPP_32         = 16'd32;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_SHORT       = 3'd1;
	localparam logic [2:0] ST_BAD_SIG     = 3'd2;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
	localparam logic [2:0] ST_BAD_SIZE    = 3'd4;
	localparam logic [2:0] ST_TRUNCATED   = 3'd5;
	localparam logic [2:0] ST_BAD_OFFSET  = 3'd6;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} bmp_in_t;

	typedef struct packed {
		logic        item_kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] row;
		logic [2:0]  status;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last;
	} bmp_out_t;

endpackage

>>> rtl/bmp_stream_rgb_decoder_unit.sv
// bmp_stream_rgb_decoder_unit: byte stream bmp header parser and bgr(a) to rgb pixel decoder
// depends on bmpd_pkg for item types, status codes and size limits
//
// channel        dir  payload     handshake
// byte_item      in   bmp_in_t    byte_valid / byte_ready
// result_item    out  bmp_out_t   result_valid / result_ready
//
// one file byte is taken per cycle while byte_ready is high; its results land in a four
// entry result queue at the same edge and are visible on the next cycle
// a byte makes at most two results (a pixel and the final status on the last byte)
// byte_ready is high while the result queue has at least two free entries
// arst_n clears the parser state and the result queue
module bmp_stream_rgb_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  bmpd_pkg::bmp_in_t  byte_item,
	output logic               result_valid,
	input  logic               result_ready,
	output bmpd_pkg::bmp_out_t result_item
);
	import bmpd_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_PIXEL  = 3'd2;
	localparam logic [2:0] PH_DONE   = 3'd3;
	localparam logic [2:0] PH_ERROR  = 3'd4;

	localparam logic [31:0] POS_SIG    = 32'd1;
	localparam logic [31:0] POS_OFFSET = 32'd13;
	localparam logic [31:0] POS_INFO   = 32'd17;
	localparam logic [31:0] POS_WIDTH  = 32'd21;
	localparam logic [31:0] POS_HEIGHT = 32'd25;
	localparam logic [31:0] POS_PLANES = 32'd27;
	localparam logic [31:0] POS_BPP    = 32'd29;
	localparam logic [31:0] POS_COMPR  = 32'd33;
	localparam logic [31:0] POS_HDREND = 32'd53;

	logic [31:0] pos_q, hs_q, off_q;
	logic [12:0] w_q, h_q;
	logic        td_q, fc_q;
	logic [2:0]  ph_q;
	logic [1:0]  bip_q, pad_q;
	logic [11:0] col_q, row_q;
	logic [7:0]  hb_q, hg_q;
	logic [2:0]  err_q;

	logic [31:0] pos_n, hs_n, off_n;
	logic [12:0] w_n, h_n;
	logic        td_n, fc_n;
	logic [2:0]  ph_n;
	logic [1:0]  bip_n, pad_n;
	logic [11:0] col_n, row_n;
	logic [7:0]  hb_n, hg_n;
	logic [2:0]  err_n;

	logic        take;
	logic [31:0] hs_new, mag;
	logic [15:0] half;
	logic        pix_emit, pix_done, row_inc;
	logic [12:0] col_inc, row_next;
	logic [1:0]  w3, pad_calc;
	logic [11:0] drow;
	logic [2:0]  st;
	bmp_out_t    pix_res, st_res, res_a, res_b;
	logic [1:0]  push_cnt;

	bmp_out_t    mem_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [2:0]  count_q;
	logic        pop;

	assign take         = byte_valid && byte_ready;
	assign byte_ready   = count_q <= 3'd2;
	assign result_valid = count_q != 3'd0;
	assign result_item  = mem_q[rd_ptr_q];
	assign pop          = result_valid && result_ready;
	assign wr_ptr_p1    = wr_ptr_q + 2'd1;

	assign hs_new   = {byte_item.data_byte, hs_q[31:8]};
	assign half     = hs_new[31:16];
	assign mag      = hs_new[31] ? (~hs_new + 32'd1) : hs_new;
	assign col_inc  = {1'b0, col_q} + 13'd1;
	assign row_next = {1'b0, row_q} + 13'd1;
	assign w3       = w_q[1:0] + {w_q[0], 1'b0};
	assign pad_calc = 2'd0 - w3;
	assign drow     = td_q ? row_q : 12'(h_q - 13'd1 - {1'b0, row_q});

	always_comb begin
		pos_n = pos_q; hs_n = hs_q; off_n = off_q; w_n = w_q; h_n = h_q;
		td_n = td_q; fc_n = fc_q; ph_n = ph_q; bip_n = bip_q; pad_n = pad_q;
		col_n = col_q; row_n = row_q; hb_n = hb_q; hg_n = hg_q; err_n = err_q;
		pix_emit = 1'b0;
		pix_done = 1'b0;
		row_inc  = 1'b0;

		if (ph_q == PH_HEADER) begin
			hs_n = hs_new;
			case (pos_q)
				POS_SIG: begin
					if (half != BMP_SIGNATURE) begin
						err_n = ST_BAD_SIG; ph_n = PH_ERROR;
					end
				end
				POS_OFFSET: off_n = hs_new;
				POS_INFO: begin
					if (hs_new < MIN_INFO_SIZE) begin
						err_n = ST_UNSUPPORTED; ph_n = PH_ERROR;
					end
				end
				POS_WIDTH: begin
					if (hs_new[31] || hs_new == 32'd0 || hs_new > 32'(MAX_WIDTH)) begin
						err_n = ST_BAD_SIZE; ph_n = PH_ERROR;
					end else begin
						w_n = hs_new[12:0];
					end
				end
				POS_HEIGHT: begin
					td_n = hs_new[31];
					if (mag == 32'd0 || mag > 32'(MAX_HEIGHT)) begin
						err_n = ST_BAD_SIZE; ph_n = PH_ERROR;
					end else begin
						h_n = mag[12:0];
					end
				end
				POS_PLANES: begin
					if (half != 16'd1) begin
						err_n = ST_UNSUPPORTED; ph_n = PH_ERROR;
					end
				end
				POS_BPP: begin
					if (half == BPP_24) begin
						fc_n = 1'b0;
					end else if (half == BPP_32) begin
						fc_n = 1'b1;
					end else begin
						err_n = ST_UNSUPPORTED; ph_n = PH_ERROR;
					end
				end
				POS_COMPR: begin
					if (hs_new != 32'd0) begin
						err_n = ST_UNSUPPORTED; ph_n = PH_ERROR;
					end
				end
				POS_HDREND: begin
					if (off_q < MIN_PIX_OFFSET) begin
						err_n = ST_BAD_OFFSET; ph_n = PH_ERROR;
					end else begin
						ph_n = PH_SKIP;
					end
				end
				default: ;
			endcase
		end else if (ph_q == PH_SKIP && pos_q >= off_q) begin
			ph_n = PH_PIXEL;
		end

		if (ph_n == PH_PIXEL && pos_q >= off_q) begin
			if (pad_q != 2'd0) begin
				pad_n = pad_q - 2'd1;
				row_inc = pad_q == 2'd1;
			end else begin
				case (bip_q)
					2'd0: begin
						hb_n = byte_item.data_byte; bip_n = 2'd1;
					end
					2'd1: begin
						hg_n = byte_item.data_byte; bip_n = 2'd2;
					end
					2'd2: begin
						pix_emit = 1'b1;
						if (fc_q) bip_n = 2'd3;
						else pix_done = 1'b1;
					end
					default: pix_done = 1'b1;
				endcase
			end
			if (pix_done) begin
				bip_n = 2'd0;
				col_n = col_inc[11:0];
				if (col_inc >= w_q) begin
					col_n = 12'd0;
					if (!fc_q && pad_calc != 2'd0) pad_n = pad_calc;
					else row_inc = 1'b1;
				end
			end
			if (row_inc) begin
				row_n = row_next[11:0];
				if (row_next >= h_q) ph_n = PH_DONE;
			end
		end

		if (pos_q != 32'hFFFF_FFFF) pos_n = pos_q + 32'd1;

		if (pos_q < POS_HDREND) st = ST_SHORT;
		else if (err_n != ST_OK) st = err_n;
		else if (ph_n == PH_DONE) st = ST_OK;
		else st = ST_TRUNCATED;

		if (byte_item.end_of_file) begin
			pos_n = '0; hs_n = '0; off_n = '0; w_n = '0; h_n = '0;
			td_n = 1'b0; fc_n = 1'b0; ph_n = PH_HEADER; bip_n = '0; pad_n = '0;
			col_n = '0; row_n = '0; hb_n = '0; hg_n = '0; err_n = ST_OK;
		end
	end

	always_comb begin
		pix_res = '0;
		pix_res.item_kind = KIND_PIXEL;
		pix_res.red       = byte_item.data_byte;
		pix_res.green     = hg_q;
		pix_res.blue      = hb_q;
		pix_res.column    = col_q;
		pix_res.row       = drow;

		st_res = '0;
		st_res.item_kind = KIND_STATUS;
		st_res.status    = st;
		st_res.last      = 1'b1;
		if (st == ST_OK) begin
			st_res.image_width  = w_q;
			st_res.image_height = h_q;
		end

		res_a    = pix_emit ? pix_res : st_res;
		res_b    = st_res;
		push_cnt = take ? ({1'b0, pix_emit} + {1'b0, byte_item.end_of_file}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; hs_q <= '0; off_q <= '0; w_q <= '0; h_q <= '0;
			td_q <= 1'b0; fc_q <= 1'b0; ph_q <= PH_HEADER; bip_q <= '0; pad_q <= '0;
			col_q <= '0; row_q <= '0; hb_q <= '0; hg_q <= '0; err_q <= ST_OK;
		end else if (take) begin
			pos_q <= pos_n; hs_q <= hs_n; off_q <= off_n; w_q <= w_n; h_q <= h_n;
			td_q <= td_n; fc_q <= fc_n; ph_q <= ph_n; bip_q <= bip_n; pad_q <= pad_n;
			col_q <= col_n; row_q <= row_n; hb_q <= hb_n; hg_q <= hg_n; err_q <= err_n;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) mem_q[wr_ptr_q] <= res_a;
		if (push_cnt == 2'd2) mem_q[wr_ptr_p1] <= res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_cnt;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_eof_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(take && byte_item.end_of_file) |=> (ph_q == PH_HEADER && pos_q == 32'd0))
		else $error("parser not back at header after last byte");

	a_pixel_past_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_PIXEL) |-> (pos_q > off_q))
		else $error("pixel phase before pixel offset");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_item.item_kind == result_item.last))
		else $error("last flag does not match status item");

	a_two_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt == 2'd2) |-> (count_q <= 3'd2))
		else $error("double push without room");

endmodule

>>> sim/tb_bmp_stream_rgb_decoder_unit.sv
`timescale 1ns / 1ps
// tb_bmp_stream_rgb_decoder_unit: table driven and random file streams for the bmp decoder
// depends on bmpd_pkg and bmp_stream_rgb_decoder_unit; scores every result against a
// local byte by byte decoder model, with checked table rows giving their own status
module tb_bmp_stream_rgb_decoder_unit;
	import bmpd_pkg::*;

	typedef enum logic [2:0] {PH_HDR, PH_SKIP, PH_PIX, PH_DONE, PH_ERR} parse_phase_t;

	localparam int NO_CHECK    = -1;
	localparam int FILL_RND    = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;
	localparam int FILL_ALT    = 3;
	localparam int PHASE_BYTES = 40;
	localparam int DIR_ROWS    = 28;

	typedef struct packed {
		logic [15:0] sig;
		logic [31:0] offset;
		logic [31:0] info;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] planes;
		logic [15:0] bpp;
		logic [31:0] comp;
		bit          exact;
		int          extra;
		int          cut;
		int          fill;
		int          exp_st;
	} file_spec_t;

	// sig, offset, info, width, height, planes, bpp, comp, exact, extra, cut, fill, status
	localparam file_spec_t DIR_TAB [DIR_ROWS] = '{
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 1, FILL_RND, ST_SHORT},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 3, FILL_RND, ST_SHORT},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 53, FILL_RND, ST_SHORT},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 54, FILL_RND, ST_TRUNCATED},
		'{16'h4D43, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIG},
		'{BMP_SIGNATURE, 32'd54, 32'd39, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_UNSUPPORTED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd2, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_UNSUPPORTED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, 16'd16, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_UNSUPPORTED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd1,
			1'b0, 8, 0, FILL_RND, ST_UNSUPPORTED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd0, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd4097, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'hFFFFFFFF, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd0, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd4097, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'hFFFFEFFF, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'h80000000, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_SIZE},
		'{BMP_SIGNATURE, 32'd53, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_OFFSET},
		'{BMP_SIGNATURE, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd1, 16'd1, BPP_32, 32'd0,
			1'b0, 8, 0, FILL_RND, ST_BAD_OFFSET},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 0, FILL_ZERO, ST_OK},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd1, 16'd1, BPP_32, 32'd0,
			1'b1, 0, 0, FILL_ONES, ST_OK},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd2, 32'hFFFFFFFE, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 0, FILL_RND, NO_CHECK},
		'{BMP_SIGNATURE, 32'd60, 32'd124, 32'd3, 32'd2, 16'd1, BPP_24, 32'd0,
			1'b1, 0, 0, FILL_ALT, NO_CHECK},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd4096, 32'd1, 16'd1, BPP_24, 32'd0,
			1'b0, 9, 0, FILL_RND, ST_TRUNCATED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'hFFFFF000, 16'd1, BPP_32, 32'd0,
			1'b0, 20, 0, FILL_RND, ST_TRUNCATED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd1, 32'd4096, 16'd1, BPP_24, 32'd0,
			1'b0, 12, 0, FILL_RND, ST_TRUNCATED},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd5, 32'd3, 16'd1, BPP_24, 32'd0,
			1'b1, 7, 0, FILL_RND, ST_OK},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd3, 32'hFFFFFFFE, 16'd1, BPP_32, 32'd0,
			1'b1, 0, 0, FILL_RND, NO_CHECK},
		'{BMP_SIGNATURE, 32'd54, 32'd40, 32'd5, 32'd2, 16'd1, BPP_24, 32'd0,
			1'b0, 31, 0, FILL_RND, ST_TRUNCATED}
	};

	logic     clk;
	logic     arst_n       = 1'b0;
	logic     byte_valid   = 1'b0;
	logic     byte_ready;
	bmp_in_t  byte_item    = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	bmp_out_t result_item;

	bmp_stream_rgb_decoder_unit dut (.*);

	int          src_idle_pct  = 0;
	int          dst_stall_pct = 0;
	int          fail_count    = 0;
	int          bytes_sent    = 0;
	int          forced_st     = NO_CHECK;
	logic [12:0] forced_w;
	logic [12:0] forced_h;
	bmp_out_t    awaited_results [$];
	logic [7:0]  file_bytes [$];
	bmp_out_t    want_item;

	// decoder model state
	logic [31:0]  m_pos, m_shift, m_offset;
	logic [12:0]  m_width, m_height, m_col, m_row;
	logic         m_top_down, m_four;
	parse_phase_t m_phase;
	logic [1:0]   m_sub, m_pad;
	logic [7:0]   m_blue, m_green;
	logic [2:0]   m_err;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("Regression FAIL");
		$finish;
	end

	function automatic string fmt_result(bmp_out_t r);
		return $sformatf("kind=%0d rgb=%02h_%02h_%02h col=%0d row=%0d st=%0d w=%0d h=%0d last=%0d",
			r.item_kind, r.red, r.green, r.blue, r.column, r.row, r.status,
			r.image_width, r.image_height, r.last);
	endfunction

	function automatic logic [31:0] height_mag(logic [31:0] h);
		return h[31] ? (~h + 32'd1) : h;
	endfunction

	function automatic int img_bytes(file_spec_t s);
		int w, rb;
		w  = int'(s.width);
		rb = (s.bpp == BPP_32) ? 4 * w : ((3 * w + 3) / 4) * 4;
		return rb * int'(height_mag(s.height));
	endfunction

	function automatic logic [7:0] fill_byte(int mode, int k);
		case (mode)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			FILL_ALT:  return k[0] ? 8'hFF : 8'h00;
			default:   return 8'($urandom);
		endcase
	endfunction

	task automatic model_clear();
		m_pos      = '0;
		m_shift    = '0;
		m_offset   = '0;
		m_width    = '0;
		m_height   = '0;
		m_col      = '0;
		m_row      = '0;
		m_top_down = 1'b0;
		m_four     = 1'b0;
		m_phase    = PH_HDR;
		m_sub      = '0;
		m_pad      = '0;
		m_blue     = '0;
		m_green    = '0;
		m_err      = '0;
	endtask

	task automatic model_fault(logic [2:0] code);
		m_err   = code;
		m_phase = PH_ERR;
	endtask

	task automatic model_row_done();
		m_row = m_row + 13'd1;
		if (m_row >= m_height)
			m_phase = PH_DONE;
	endtask

	task automatic model_pixel_done();
		int pad;
		m_sub = '0;
		m_col = m_col + 13'd1;
		if (m_col >= m_width) begin
			m_col = '0;
			pad   = m_four ? 0 : (4 - (int'(m_width) * 3) % 4) % 4;
			if (pad != 0)
				m_pad = pad[1:0];
			else
				model_row_done();
		end
	endtask

	task automatic model_header(logic [31:0] p);
		logic [31:0] hs, mag;
		logic [15:0] half;
		hs   = m_shift;
		half = hs[31:16];
		case (p)
			32'd1: if (half != BMP_SIGNATURE) model_fault(ST_BAD_SIG);
			32'd13: m_offset = hs;
			32'd17: if (hs < MIN_INFO_SIZE) model_fault(ST_UNSUPPORTED);
			32'd21: begin
				if (hs[31] || hs == 32'd0 || hs > MAX_WIDTH)
					model_fault(ST_BAD_SIZE);
				else
					m_width = hs[12:0];
			end
			32'd25: begin
				mag        = height_mag(hs);
				m_top_down = hs[31];
				if (mag == 32'd0 || mag > MAX_HEIGHT)
					model_fault(ST_BAD_SIZE);
				else
					m_height = mag[12:0];
			end
			32'd27: if (half != 16'd1) model_fault(ST_UNSUPPORTED);
			32'd29: begin
				if (half == BPP_24)
					m_four = 1'b0;
				else if (half == BPP_32)
					m_four = 1'b1;
				else
					model_fault(ST_UNSUPPORTED);
			end
			32'd33: if (hs != 32'd0) model_fault(ST_UNSUPPORTED);
			32'd53: begin
				if (m_offset < MIN_PIX_OFFSET)
					model_fault(ST_BAD_OFFSET);
				else
					m_phase = PH_SKIP;
			end
			default: ;
		endcase
	endtask

	task automatic model_bmp_byte(bmp_in_t it);
		logic [31:0] p;
		logic [7:0]  b;
		logic [12:0] drow;
		logic [2:0]  st;
		bmp_out_t    r;
		p = m_pos;
		b = it.data_byte;
		if (m_phase == PH_HDR) begin
			m_shift = {b, m_shift[31:8]};
			model_header(p);
		end else if (m_phase == PH_SKIP && p >= m_offset) begin
			m_phase = PH_PIX;
		end
		if (m_phase == PH_PIX && p >= m_offset) begin
			if (m_pad != 2'd0) begin
				m_pad = m_pad - 2'd1;
				if (m_pad == 2'd0)
					model_row_done();
			end else if (m_sub == 2'd0) begin
				m_blue = b;
				m_sub  = 2'd1;
			end else if (m_sub == 2'd1) begin
				m_green = b;
				m_sub   = 2'd2;
			end else if (m_sub == 2'd2) begin
				drow        = m_top_down ? m_row : (m_height - 13'd1 - m_row);
				r           = '0;
				r.item_kind = KIND_PIXEL;
				r.red       = b;
				r.green     = m_green;
				r.blue      = m_blue;
				r.column    = m_col[11:0];
				r.row       = drow[11:0];
				awaited_results.push_back(r);
				if (m_four)
					m_sub = 2'd3;
				else
					model_pixel_done();
			end else begin
				model_pixel_done();
			end
		end
		if (m_pos != 32'hFFFFFFFF)
			m_pos = m_pos + 32'd1;
		if (it.end_of_file) begin
			if (p < MIN_PIX_OFFSET - 32'd1)
				st = ST_SHORT;
			else if (m_err != 3'd0)
				st = m_err;
			else if (m_phase == PH_DONE)
				st = ST_OK;
			else
				st = ST_TRUNCATED;
			r           = '0;
			r.item_kind = KIND_STATUS;
			r.status    = st;
			r.last      = 1'b1;
			if (st == ST_OK) begin
				r.image_width  = m_width;
				r.image_height = m_height;
			end
			// typed table rows take their status as written
			if (forced_st != NO_CHECK) begin
				r.status       = forced_st[2:0];
				r.image_width  = (forced_st == ST_OK) ? forced_w : '0;
				r.image_height = (forced_st == ST_OK) ? forced_h : '0;
			end
			awaited_results.push_back(r);
			model_clear();
		end
	endtask

	task automatic send_byte(bmp_in_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		model_bmp_byte(it);
		bytes_sent++;
	endtask

	task automatic send_file();
		bmp_in_t it;
		for (int k = 0; k < file_bytes.size(); k++) begin
			it.data_byte   = file_bytes[k];
			it.end_of_file = (k == file_bytes.size() - 1);
			send_byte(it);
		end
	endtask

	task automatic build_file(file_spec_t s);
		logic [7:0] b;
		int gap, body;
		file_bytes.delete();
		for (int i = 0; i < 54; i++) begin
			if (i < 2)
				b = s.sig[8*i +: 8];
			else if (i >= 10 && i < 14)
				b = s.offset[8*(i-10) +: 8];
			else if (i >= 14 && i < 18)
				b = s.info[8*(i-14) +: 8];
			else if (i >= 18 && i < 22)
				b = s.width[8*(i-18) +: 8];
			else if (i >= 22 && i < 26)
				b = s.height[8*(i-22) +: 8];
			else if (i >= 26 && i < 28)
				b = s.planes[8*(i-26) +: 8];
			else if (i >= 28 && i < 30)
				b = s.bpp[8*(i-28) +: 8];
			else if (i >= 30 && i < 34)
				b = s.comp[8*(i-30) +: 8];
			else
				b = 8'($urandom);
			file_bytes.push_back(b);
		end
		gap  = (s.offset > 32'd54 && s.offset < 32'd256) ? int'(s.offset) - 54 : 0;
		body = (s.exact ? img_bytes(s) : 0) + s.extra;
		for (int k = 0; k < gap + body; k++)
			file_bytes.push_back(fill_byte(s.fill, k));
		if (s.cut > 0)
			while (file_bytes.size() > s.cut)
				void'(file_bytes.pop_back());
	endtask

	task automatic run_spec(file_spec_t s);
		logic [31:0] mag;
		mag       = height_mag(s.height);
		forced_st = s.exp_st;
		forced_w  = s.width[12:0];
		forced_h  = mag[12:0];
		build_file(s);
		send_file();
		forced_st = NO_CHECK;
	endtask

	task automatic random_file();
		file_spec_t s;
		int r, n;
		s = '{BMP_SIGNATURE, MIN_PIX_OFFSET, MIN_INFO_SIZE, 32'd1, 32'd1, 16'd1, BPP_24,
			32'd0, 1'b1, 0, 0, FILL_RND, NO_CHECK};
		s.width  = $urandom_range(1, 6);
		s.height = $urandom_range(1, 4);
		if ($urandom_range(2) == 0)
			s.height = ~s.height + 32'd1;
		if ($urandom_range(1) == 1)
			s.bpp = BPP_32;
		if ($urandom_range(3) == 0)
			s.offset = MIN_PIX_OFFSET + $urandom_range(1, 8);
		if ($urandom_range(3) == 0)
			s.info = MIN_INFO_SIZE + $urandom_range(200);
		r = $urandom_range(99);
		if (r < 12) begin
			s.extra = $urandom_range(1, 6);
		end else if (r < 24) begin
			s.exact = 1'b0;
			s.extra = $urandom_range(0, img_bytes(s) - 1);
		end else if (r < 36) begin
			s.exact = 1'b0;
			s.extra = $urandom_range(0, 16);
			case ($urandom_range(7))
				0: s.sig    = 16'($urandom);
				1: s.info   = $urandom_range(39);
				2: s.planes = 16'($urandom);
				3: s.bpp    = 16'($urandom);
				4: s.comp   = $urandom;
				5: s.width  = $urandom;
				6: s.height = ($urandom_range(1) == 1) ? 32'd0 : $urandom;
				default: s.offset = $urandom_range(53);
			endcase
		end else if (r < 41) begin
			s.cut = $urandom_range(1, 53);
		end
		if (r >= 96) begin
			file_bytes.delete();
			n = $urandom_range(1, 90);
			repeat (n) file_bytes.push_back(8'($urandom));
		end else begin
			build_file(s);
		end
		send_file();
	endtask

	task automatic note_mismatch(string what, bmp_out_t want, bmp_out_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: expected %s, actual %s", $time, what, fmt_result(want),
				fmt_result(got));
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("item with nothing awaited", '0, result_item);
			end else begin
				want_item = awaited_results.pop_front();
				if (result_item !== want_item)
					note_mismatch("item mismatch", want_item, result_item);
			end
		end
		result_ready <= ($urandom_range(99) >= dst_stall_pct);
	end

	initial begin
		model_clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			run_spec(DIR_TAB[i]);
		// hold off until the decoder has drained
		byte_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct  = 0;
					dst_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 67;
					dst_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					dst_stall_pct = 67;
				end
				default: begin
					src_idle_pct  = 8;
					dst_stall_pct = 8;
				end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES)
				random_file();
		end
		byte_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
